@@ sv/lvltrk_pkg.sv @@
// ---------------------------------------------------------------------------
// lvltrk_pkg
// Shared types, register indexes, action and quadrant codes and the
// event delta table of the two-axis level tracker.
// ---------------------------------------------------------------------------
package lvltrk_pkg;

   localparam int FRAC_BITS  = 14;
   localparam int ONE        = 1 << FRAC_BITS;
   localparam int LEVEL_W    = 16;
   localparam int RATE_W     = 15;
   localparam int TICK_W     = 16;
   localparam int KIND_W     = 4;
   localparam int KIND_COUNT = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_ENABLE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_RATE        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_RATE        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASELINE_VALENCE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BASELINE_AROUSAL = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_AFTER_TICKS = 3'd5;

   localparam logic ACT_EVENT = 1'b0;
   localparam logic ACT_TICK  = 1'b1;

   localparam logic [1:0] QUAD_POS_HIGH = 2'd0;
   localparam logic [1:0] QUAD_POS_LOW  = 2'd1;
   localparam logic [1:0] QUAD_NEG_HIGH = 2'd2;
   localparam logic [1:0] QUAD_NEG_LOW  = 2'd3;

   localparam int RST_LEVEL     = (ONE * 2 + 5) / 10;
   localparam int RST_SLOW_RATE = (ONE + 50) / 100;
   localparam int RST_FAST_RATE = (ONE + 10) / 20;
   localparam int RST_FAST_AFTER = 15;

   typedef struct packed {
      logic              action;
      logic [KIND_W-1:0] event_kind;
   } req_type;

   typedef struct packed {
      logic signed [LEVEL_W-1:0] valence_out;
      logic signed [LEVEL_W-1:0] arousal_out;
      logic [1:0]                quadrant;
      logic                      reported;
   } rsp_type;

   // units of 0.05, halves rounded away from zero
   function automatic logic signed [LEVEL_W-1:0] unit_delta(input int units);
      int mag;
      mag = ((units < 0 ? -units : units) * ONE + 10) / 20;
      return LEVEL_W'(units < 0 ? -mag : mag);
   endfunction

   localparam logic signed [LEVEL_W-1:0] DELTA_V [KIND_COUNT] = '{
      unit_delta(-16), unit_delta(-6), unit_delta(4), unit_delta(2),
      unit_delta(1), unit_delta(-4), unit_delta(2), unit_delta(6),
      unit_delta(10), unit_delta(8), unit_delta(2), unit_delta(0),
      unit_delta(0)
   };

   localparam logic signed [LEVEL_W-1:0] DELTA_A [KIND_COUNT] = '{
      unit_delta(18), unit_delta(14), unit_delta(8), unit_delta(6),
      unit_delta(4), unit_delta(6), unit_delta(2), unit_delta(-2),
      unit_delta(-6), unit_delta(12), unit_delta(6), unit_delta(4),
      unit_delta(-2)
   };

endpackage

@@ sv/two_axis_level_tracker_with_decay_core.sv @@
// ---------------------------------------------------------------------------
// two_axis_level_tracker_with_decay_core
// Tracks valence and arousal levels in Q2.14, applies event deltas with
// saturation and decays both levels toward their baselines on ticks.
// ---------------------------------------------------------------------------
//  channel   direction  ports                          beat
//  req       in         req_valid req_stall req_data   action, event_kind
//  rsp       out        rsp_valid rsp_stall rsp_data   levels, quadrant, reported
//  csr       in         csr_wen csr_index csr_wdata    one register write
//
//  one beat per cycle unless rsp_stall holds; a beat passes input then result reg
//  the item is registered, then add, clamp and decay logic updates the state
//  and the result register at the same edge
//  reset restores levels to 0.2, clears the tick counter and loads the
//  register defaults
//  rsp_stall holds the result; the input register keeps accepting until full
// ---------------------------------------------------------------------------
module two_axis_level_tracker_with_decay_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  lvltrk_pkg::req_type                req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output lvltrk_pkg::rsp_type                rsp_data,
   input  logic                               csr_wen,
   input  logic [lvltrk_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lvltrk_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lvltrk_pkg::*;

   localparam int SUM_W = LEVEL_W + 3;
   localparam int DIFF_W = LEVEL_W + 2;
   localparam logic signed [SUM_W-1:0] ONE_X = SUM_W'(ONE);
   localparam logic signed [SUM_W-1:0] NEG_ONE_X = -SUM_W'(ONE);
   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

   function automatic logic signed [LEVEL_W-1:0] clamp_lvl(
      input logic signed [SUM_W-1:0] x);
      logic signed [SUM_W-1:0] r;
      r = x;
      if (x > ONE_X) begin
         r = ONE_X;
      end else if (x < NEG_ONE_X) begin
         r = NEG_ONE_X;
      end
      return r[LEVEL_W-1:0];
   endfunction

   function automatic logic signed [LEVEL_W-1:0] decay_axis(
      input logic signed [LEVEL_W-1:0] level,
      input logic signed [LEVEL_W-1:0] base,
      input logic [RATE_W-1:0]         rate);
      logic signed [DIFF_W-1:0] diff;
      logic signed [DIFF_W-1:0] rate_s;
      logic signed [DIFF_W-1:0] step;
      diff   = DIFF_W'(base) - DIFF_W'(level);
      rate_s = signed'({{(DIFF_W-RATE_W){1'b0}}, rate});
      if (diff > 0) begin
         step = (diff < rate_s) ? diff : rate_s;
      end else begin
         step = (diff > -rate_s) ? diff : -rate_s;
      end
      return clamp_lvl(SUM_W'(level) + SUM_W'(step));
   endfunction

   // configuration
   logic                       decay_en_ff;
   logic [RATE_W-1:0]          slow_rate_ff;
   logic [RATE_W-1:0]          fast_rate_ff;
   logic signed [LEVEL_W-1:0]  base_v_ff;
   logic signed [LEVEL_W-1:0]  base_a_ff;
   logic [TICK_W-1:0]          fast_after_ff;

   // state
   logic signed [LEVEL_W-1:0]  valence_ff, valence_in;
   logic signed [LEVEL_W-1:0]  arousal_ff, arousal_in;
   logic [TICK_W-1:0]          ticks_ff, ticks_in;

   // pipeline
   logic                       s1_vld_ff;
   req_type                    s1_ff;
   logic                       rsp_vld_ff;
   rsp_type                    rsp_ff, rsp_in;
   logic                       out_free;
   logic                       advance;
   logic                       req_take;

   logic                       known;
   logic [KIND_W-1:0]          kind;
   logic signed [LEVEL_W-1:0]  dv, da;
   logic [RATE_W-1:0]          rate;

   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign advance   = s1_vld_ff && out_free;
   assign req_stall = s1_vld_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_en_ff   <= 1'b1;
         slow_rate_ff  <= RATE_W'(RST_SLOW_RATE);
         fast_rate_ff  <= RATE_W'(RST_FAST_RATE);
         base_v_ff     <= LEVEL_W'(RST_LEVEL);
         base_a_ff     <= LEVEL_W'(RST_LEVEL);
         fast_after_ff <= TICK_W'(RST_FAST_AFTER);
      end else if (csr_wen) begin
         case (csr_index)
            CSR_DECAY_ENABLE:     decay_en_ff   <= csr_wdata[0];
            CSR_SLOW_RATE:        slow_rate_ff  <= csr_wdata[RATE_W-1:0];
            CSR_FAST_RATE:        fast_rate_ff  <= csr_wdata[RATE_W-1:0];
            CSR_BASELINE_VALENCE: base_v_ff     <= csr_wdata[LEVEL_W-1:0];
            CSR_BASELINE_AROUSAL: base_a_ff     <= csr_wdata[LEVEL_W-1:0];
            CSR_FAST_AFTER_TICKS: fast_after_ff <= csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      kind       = s1_ff.event_kind;
      known      = 32'(kind) < KIND_COUNT;
      dv         = known ? DELTA_V[kind] : '0;
      da         = known ? DELTA_A[kind] : '0;
      valence_in = valence_ff;
      arousal_in = arousal_ff;
      ticks_in   = ticks_ff;
      rate       = slow_rate_ff;
      rsp_in.reported = 1'b0;
      if (s1_ff.action == ACT_EVENT) begin
         ticks_in = '0;
         if (known) begin
            valence_in = clamp_lvl(SUM_W'(valence_ff) + SUM_W'(dv));
            arousal_in = clamp_lvl(SUM_W'(arousal_ff) + SUM_W'(da));
            rsp_in.reported = 1'b1;
         end
      end else begin
         if (ticks_ff != TICK_MAX) begin
            ticks_in = ticks_ff + 1'b1;
         end
         if (ticks_in >= fast_after_ff) begin
            rate = fast_rate_ff;
         end
         if (decay_en_ff) begin
            valence_in = decay_axis(valence_ff, base_v_ff, rate);
            arousal_in = decay_axis(arousal_ff, base_a_ff, rate);
         end
      end
      rsp_in.valence_out = valence_in;
      rsp_in.arousal_out = arousal_in;
      if (valence_in > 0) begin
         rsp_in.quadrant = (arousal_in > 0) ? QUAD_POS_HIGH : QUAD_POS_LOW;
      end else begin
         rsp_in.quadrant = (arousal_in > 0) ? QUAD_NEG_HIGH : QUAD_NEG_LOW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valence_ff <= LEVEL_W'(RST_LEVEL);
         arousal_ff <= LEVEL_W'(RST_LEVEL);
         ticks_ff   <= '0;
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (advance) begin
            valence_ff <= valence_in;
            arousal_ff <= arousal_in;
            ticks_ff   <= ticks_in;
         end
         if (req_take) begin
            s1_vld_ff <= 1'b1;
         end else if (advance) begin
            s1_vld_ff <= 1'b0;
         end
         if (advance) begin
            rsp_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // levels stay inside [-1, +1]
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      (32'(valence_ff) <= ONE) && (32'(valence_ff) >= -ONE) &&
      (32'(arousal_ff) <= ONE) && (32'(arousal_ff) >= -ONE))
      else $error("level out of range");

   // a pending result always shows the current state
   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_ff.valence_out == valence_ff) &&
                     (rsp_ff.arousal_out == arousal_ff))
      else $error("result differs from state");

   // a tick is never reported
   a_tick_not_reported: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_ff.action == ACT_TICK) |=> !rsp_ff.reported)
      else $error("tick reported");

   // any event restarts the counter
   a_event_clears_ticks: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_ff.action == ACT_EVENT) |=> (ticks_ff == '0))
      else $error("counter not restarted");

endmodule

@@ bench/two_axis_level_tracker_with_decay_core_test.sv @@
// ---------------------------------------------------------------------------
// two_axis_level_tracker_with_decay_core_test
// Self-checking bench for the level tracker. A driver feeds event and tick
// beats from a queue, a monitor checks every result beat against an
// in-bench model of both levels, the tick counter and the registers. Runs
// directed corners, a long tick run across the fast threshold and random
// phases under several register settings with random gaps and stalls.
// ---------------------------------------------------------------------------
module two_axis_level_tracker_with_decay_core_test;
   import lvltrk_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 200;
   localparam int RAND_PHASES = 8;

   localparam int V_UNITS [KIND_COUNT] = '{-16, -6, 4, 2, 1, -4, 2, 6, 10, 8, 2, 0, 0};
   localparam int A_UNITS [KIND_COUNT] = '{18, 14, 8, 6, 4, 6, 2, -2, -6, 12, 6, 4, -2};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_DECAY_ENABLE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // model state and register shadow
   int valence_lvl;
   int arousal_lvl;
   int ticks_seen;
   bit cfg_decay;
   int cfg_slow;
   int cfg_fast;
   int cfg_base_v;
   int cfg_base_a;
   int cfg_fast_after;

   req_type pending_items[$];
   rsp_type expected_levels[$];
   int items_queued = 0;
   int results_checked = 0;
   int fail_count = 0;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   int req_gap = 0;
   int rsp_wait = 0;
   int rsp_hold = 0;
   int hold_reqs = 0;
   int holds_taken = 0;
   int rsp_draw;
   int quiet_cycles = 0;
   rsp_type want;

   two_axis_level_tracker_with_decay_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wen(csr_wen),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int delta_q(input int units);
      int mag;
      mag = ((units < 0 ? -units : units) * ONE * 2 + 20) / 40;
      return (units < 0) ? -mag : mag;
   endfunction

   function automatic int sat_level(input int x);
      if (x > ONE) return ONE;
      if (x < -ONE) return -ONE;
      return x;
   endfunction

   function automatic int pull_toward(input int lvl, input int base, input int rate);
      int diff;
      int step;
      diff = base - lvl;
      if (diff > 0) step = (diff < rate) ? diff : rate;
      else step = (diff > -rate) ? diff : -rate;
      return sat_level(lvl + step);
   endfunction

   function automatic rsp_type track_levels(input req_type it);
      rsp_type r;
      int rate;
      r.reported = 1'b0;
      if (it.action == ACT_EVENT) begin
         ticks_seen = 0;
         if (it.event_kind < KIND_COUNT) begin
            valence_lvl = sat_level(valence_lvl + delta_q(V_UNITS[it.event_kind]));
            arousal_lvl = sat_level(arousal_lvl + delta_q(A_UNITS[it.event_kind]));
            r.reported = 1'b1;
         end
      end else begin
         if (ticks_seen < 65535) ticks_seen++;
         if (cfg_decay) begin
            rate = (ticks_seen >= cfg_fast_after) ? cfg_fast : cfg_slow;
            valence_lvl = pull_toward(valence_lvl, cfg_base_v, rate);
            arousal_lvl = pull_toward(arousal_lvl, cfg_base_a, rate);
         end
      end
      if (valence_lvl > 0) r.quadrant = (arousal_lvl > 0) ? QUAD_POS_HIGH : QUAD_POS_LOW;
      else r.quadrant = (arousal_lvl > 0) ? QUAD_NEG_HIGH : QUAD_NEG_LOW;
      r.valence_out = LEVEL_W'(valence_lvl);
      r.arousal_out = LEVEL_W'(arousal_lvl);
      return r;
   endfunction

   function automatic int draw_wait(input bit calm);
      return calm ? 0 : $urandom_range(0, 11);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_rate();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'd1;
         2: return 16'(ONE);
         3: return 16'($urandom_range(0, 65535));
         4: return 16'($urandom_range(1, 400));
         default: return 16'($urandom_range(0, ONE));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_base();
      case ($urandom_range(0, 4))
         0: return 16'(-ONE);
         1: return 16'(ONE);
         2: return 16'd0;
         3: return 16'($urandom_range(0, 2 * ONE) - ONE);
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         CSR_DECAY_ENABLE:     cfg_decay = val[0];
         CSR_SLOW_RATE:        cfg_slow = int'(val[RATE_W-1:0]);
         CSR_FAST_RATE:        cfg_fast = int'(val[RATE_W-1:0]);
         CSR_BASELINE_VALENCE: cfg_base_v = int'($signed(val));
         CSR_BASELINE_AROUSAL: cfg_base_a = int'($signed(val));
         CSR_FAST_AFTER_TICKS: cfg_fast_after = int'(val);
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [CSR_DATA_W-1:0] en, input logic [CSR_DATA_W-1:0] slow,
                            input logic [CSR_DATA_W-1:0] fast, input logic [CSR_DATA_W-1:0] bv,
                            input logic [CSR_DATA_W-1:0] ba, input logic [CSR_DATA_W-1:0] after);
      write_csr(CSR_DECAY_ENABLE, en);
      write_csr(CSR_SLOW_RATE, slow);
      write_csr(CSR_FAST_RATE, fast);
      write_csr(CSR_BASELINE_VALENCE, bv);
      write_csr(CSR_BASELINE_AROUSAL, ba);
      write_csr(CSR_FAST_AFTER_TICKS, after);
   endtask

   task automatic queue_item(input logic act, input int kind);
      req_type it;
      it.action = act;
      it.event_kind = KIND_W'(kind);
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic drain();
      while (results_checked != items_queued) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_levels.push_back(track_levels(req_data));
         if (!(req_valid && req_stall)) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               req_data <= pending_items.pop_front();
               req_valid <= 1'b1;
               req_gap <= draw_wait(req_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait <= 0;
         rsp_hold <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_levels.size() == 0) begin
               $error("result beat with no expected value");
               fail_count++;
            end else begin
               want = expected_levels.pop_front();
               if (rsp_data.valence_out !== want.valence_out) begin
                  $error("valence_out: expected %0d, got %0d",
                         want.valence_out, rsp_data.valence_out);
                  fail_count++;
               end
               if (rsp_data.arousal_out !== want.arousal_out) begin
                  $error("arousal_out: expected %0d, got %0d",
                         want.arousal_out, rsp_data.arousal_out);
                  fail_count++;
               end
               if (rsp_data.quadrant !== want.quadrant) begin
                  $error("quadrant: expected %0d, got %0d", want.quadrant, rsp_data.quadrant);
                  fail_count++;
               end
               if (rsp_data.reported !== want.reported) begin
                  $error("reported: expected %0d, got %0d", want.reported, rsp_data.reported);
                  fail_count++;
               end
               results_checked++;
            end
         end
         if (hold_reqs != holds_taken) begin
            holds_taken++;
            rsp_hold <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (rsp_hold > 0) begin
            rsp_hold <= rsp_hold - 1;
            rsp_stall <= 1'b1;
         end else if (rsp_valid && !rsp_stall) begin
            rsp_draw = draw_wait(rsp_calm);
            rsp_wait <= rsp_draw;
            rsp_stall <= (rsp_draw > 0);
         end else if (rsp_wait > 0) begin
            rsp_wait <= rsp_wait - 1;
            rsp_stall <= (rsp_wait > 1);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int p;
      int k;
      int start;
      logic [CSR_DATA_W-1:0] after;

      valence_lvl = RST_LEVEL;
      arousal_lvl = RST_LEVEL;
      ticks_seen = 0;
      cfg_decay = 1'b1;
      cfg_slow = RST_SLOW_RATE;
      cfg_fast = RST_FAST_RATE;
      cfg_base_v = RST_LEVEL;
      cfg_base_a = RST_LEVEL;
      cfg_fast_after = RST_FAST_AFTER;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: every kind incl. unknown, saturation at the upper bound, ticks
      for (k = 0; k < 16; k++) queue_item(ACT_EVENT, k);
      queue_item(ACT_EVENT, 0);
      queue_item(ACT_EVENT, 0);
      queue_item(ACT_EVENT, 8);
      for (k = 0; k < 5; k++) queue_item(ACT_TICK, (k % 2) ? 15 : 0);
      drain();

      // long tick run; fast rate takes over at the threshold and stays
      req_calm = 1'b1;
      rsp_calm = 1'b1;
      write_all(16'd1, 16'd0, 16'd1, 16'(ONE), 16'(-ONE), 16'd150);
      queue_item(ACT_EVENT, 13);
      for (k = 0; k < 200; k++) queue_item(ACT_TICK, k % 16);
      drain();

      for (p = 0; p < RAND_PHASES; p++) begin
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         case (p)
            0: write_all(16'd1, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h0000);
            1: write_all(16'd1, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
            2: write_all(16'd1, 16'(ONE), 16'(ONE), 16'(-ONE), 16'(ONE), 16'd1);
            3: write_all(16'hFFFE, pick_rate(), pick_rate(), pick_base(), pick_base(),
                         16'($urandom_range(0, 40)));
            default: begin
               case ($urandom_range(0, 3))
                  0: after = 16'd0;
                  1: after = 16'($urandom_range(1, 40));
                  2: after = 16'hFFFF;
                  default: after = 16'($urandom_range(0, 65535));
               endcase
               write_all(16'($urandom_range(0, 3) != 0), pick_rate(), pick_rate(),
                         pick_base(), pick_base(), after);
            end
         endcase
         if (p == 4) req_calm = 1'b1;
         start = items_queued;
         while (items_queued - start < PHASE_ITEMS) begin
            k = $urandom_range(0, 9);
            if (k < 6) begin
               repeat ($urandom_range(1, 3)) queue_item(ACT_EVENT, $urandom_range(0, 12));
               repeat ($urandom_range(1, 40)) queue_item(ACT_TICK, $urandom_range(0, 15));
            end else if (k < 8) begin
               queue_item(ACT_EVENT, $urandom_range(0, 15));
            end else begin
               queue_item(ACT_TICK, $urandom_range(0, 15));
            end
         end
         if (p == 4) hold_reqs++;
         drain();
      end

      repeat (5) @(posedge clock);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
